// ===== hw/rtl/aibs_pkg.sv =====
// ----------------------------------------------------------------------------
// aibs_pkg
// Shared types, codes and helpers of the aligned image buffer size block.
// ----------------------------------------------------------------------------
package aibs_pkg;

    localparam int FMT_W    = 3;
    localparam int BATCH_W  = 9;
    localparam int CHAN_W   = 3;
    localparam int DIM_W    = 14;
    localparam int TOTAL_W  = 40;
    localparam int STATUS_W = 2;
    localparam int ALIGN_W  = 4;
    localparam int STRIDE_W = 34;
    localparam int NSTG     = 7;

    localparam logic [FMT_W-1:0] FMT_YUV420     = 3'd0;
    localparam logic [FMT_W-1:0] FMT_NV12       = 3'd1;
    localparam logic [FMT_W-1:0] FMT_RGB_PLANAR = 3'd2;
    localparam logic [FMT_W-1:0] FMT_PACKED     = 3'd3;

    localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
    localparam logic [STATUS_W-1:0] ST_UNSUPPORTED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_YUV_CHAN    = 2'd2;

    localparam logic [CHAN_W-1:0] YUV_CHANNELS = 3'd3;

    localparam logic [1:0] REG_LUMA_ROW = 2'd0;
    localparam logic [1:0] REG_ROW      = 2'd1;
    localparam logic [1:0] REG_PLANE    = 2'd2;

    localparam logic [ALIGN_W-1:0] ALIGN_RESET = 4'd6;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    typedef struct packed {
        logic [ALIGN_W-1:0] luma_row;
        logic [ALIGN_W-1:0] row;
        logic [ALIGN_W-1:0] plane;
    } t_align_cfg;

    function automatic logic [STRIDE_W-1:0] round_to_align(input logic [STRIDE_W-1:0] x,
                                                           input logic [ALIGN_W-1:0] k);
        logic [STRIDE_W-1:0] m;
        m = (STRIDE_W'(1) << k) - STRIDE_W'(1);
        return (x + m) & ~m;
    endfunction

endpackage

// ===== hw/rtl/aibs_if.sv =====
// ----------------------------------------------------------------------------
// aibs_if
// Valid/ready channels for size queries and size results.
// ----------------------------------------------------------------------------
interface aibs_in_if;
    import aibs_pkg::*;

    logic                valid;
    logic                ready;
    logic [FMT_W-1:0]    format_class;
    logic [BATCH_W-1:0]  batch_count;
    logic [CHAN_W-1:0]   channel_count;
    logic [DIM_W-1:0]    height;
    logic [DIM_W-1:0]    width;

    modport source (output valid, format_class, batch_count, channel_count, height, width,
                    input ready);
    modport sink   (input valid, format_class, batch_count, channel_count, height, width,
                    output ready);
endinterface

interface aibs_out_if;
    import aibs_pkg::*;

    logic                valid;
    logic                ready;
    logic [TOTAL_W-1:0]  total_bytes;
    logic [STATUS_W-1:0] status;

    modport source (output valid, total_bytes, status, input ready);
    modport sink   (input valid, total_bytes, status, output ready);
endinterface

// ===== hw/rtl/aligned_image_buffer_size.sv =====
// ----------------------------------------------------------------------------
// aligned_image_buffer_size
// Byte size of a batch of aligned yuv / rgb image buffers, with alignment
// exponents in apb registers.
// ----------------------------------------------------------------------------
// channel   dir  fields
// i_req     in   format_class, batch_count, channel_count, height, width
// o_rsp     out  total_bytes, status
// apb       in   luma_row_align_log2, row_align_log2, plane_align_log2
//
// one transfer per cycle sustained while o_rsp is ready; each result
// passes through the seven register stages of the pipe before o_rsp offers it
// reset clears all stage valid bits and loads 6 into every alignment register
// a stalled output holds its stage; upstream stages keep filling any empty
// slot, so i_req.ready drops only with all seven stages full
// ----------------------------------------------------------------------------
module aligned_image_buffer_size (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    aibs_in_if.sink     i_req,
    aibs_out_if.source  o_rsp
);
    import aibs_pkg::*;

    t_align_cfg r_cfg;
    logic       w_wr;
    logic [1:0] w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.luma_row <= ALIGN_RESET;
            r_cfg.row      <= ALIGN_RESET;
            r_cfg.plane    <= ALIGN_RESET;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_LUMA_ROW: r_cfg.luma_row <= pwdata[ALIGN_W-1:0];
                REG_ROW:      r_cfg.row      <= pwdata[ALIGN_W-1:0];
                REG_PLANE:    r_cfg.plane    <= pwdata[ALIGN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_LUMA_ROW: prdata = {28'd0, r_cfg.luma_row};
            REG_ROW:      prdata = {28'd0, r_cfg.row};
            REG_PLANE:    prdata = {28'd0, r_cfg.plane};
            default:      prdata = '0;
        endcase
    end

    aibs_pipe u_pipe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .s_in    (i_req),
        .m_out   (o_rsp)
    );

endmodule

// ===== hw/rtl/aibs_pipe.sv =====
// ----------------------------------------------------------------------------
// aibs_pipe
// Seven stage size pipeline: row widths, row-by-height products, plane
// rounding, stride select, batch product, saturation.
// ----------------------------------------------------------------------------
module aibs_pipe (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  aibs_pkg::t_align_cfg i_cfg,
    aibs_in_if.sink              s_in,
    aibs_out_if.source           m_out
);
    import aibs_pkg::*;

    logic [NSTG:1] r_v;
    logic [NSTG:1] w_en;

    // stage 1: aligned row widths
    logic [FMT_W-1:0]    r1_fmt;
    logic [BATCH_W-1:0]  r1_n;
    logic [CHAN_W-1:0]   r1_c;
    logic [DIM_W-1:0]    r1_h;
    logic [DIM_W-2:0]    r1_hh;
    logic [15:0]         r1_yw;
    logic [15:0]         r1_cwh;
    logic [15:0]         r1_cwf;
    logic [17:0]         r1_row;
    logic [STATUS_W-1:0] r1_st;
    logic [STATUS_W-1:0] n1_st;
    logic [16:0]         n1_wc;
    logic [STRIDE_W-1:0] n1_yw;
    logic [STRIDE_W-1:0] n1_cwh;
    logic [STRIDE_W-1:0] n1_cwf;
    logic [STRIDE_W-1:0] n1_row;

    // stage 2: products with height
    logic [FMT_W-1:0]    r2_fmt;
    logic [BATCH_W-1:0]  r2_n;
    logic [CHAN_W-1:0]   r2_c;
    logic [STATUS_W-1:0] r2_st;
    logic [31:0]         r2_m1;
    logic [28:0]         r2_m2;
    logic [17:0]         n2_sel1;
    logic [15:0]         n2_sel2;

    // stage 3: first plane rounding
    logic [FMT_W-1:0]    r3_fmt;
    logic [BATCH_W-1:0]  r3_n;
    logic [CHAN_W-1:0]   r3_c;
    logic [STATUS_W-1:0] r3_st;
    logic [31:0]         r3_m1;
    logic [28:0]         r3_m2;
    logic [STRIDE_W-1:0] r3_u;

    // stage 4: second plane
    logic [FMT_W-1:0]    r4_fmt;
    logic [BATCH_W-1:0]  r4_n;
    logic [CHAN_W-1:0]   r4_c;
    logic [STATUS_W-1:0] r4_st;
    logic [31:0]         r4_m1;
    logic [28:0]         r4_m2;
    logic [STRIDE_W-1:0] r4_u;
    logic [STRIDE_W-1:0] r4_v;

    // stage 5: stride per image
    logic [BATCH_W-1:0]  r5_n;
    logic [STATUS_W-1:0] r5_st;
    logic [STRIDE_W-1:0] r5_stride;
    logic [STRIDE_W-1:0] n5_stride;

    // stage 6: batch product
    logic [STATUS_W-1:0] r6_st;
    logic [BATCH_W+STRIDE_W-1:0] r6_prod;

    // stage 7: result register
    logic [TOTAL_W-1:0]  r7_total;
    logic [STATUS_W-1:0] r7_st;

    always_comb begin
        w_en[NSTG] = !r_v[NSTG] || m_out.ready;
        for (int k = NSTG - 1; k >= 1; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[1]) begin
                r_v[1] <= s_in.valid;
            end
            for (int k = 2; k <= NSTG; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    always_comb begin
        if (s_in.format_class > FMT_PACKED) begin
            n1_st = ST_UNSUPPORTED;
        end else if (s_in.format_class == FMT_YUV420 && s_in.channel_count != YUV_CHANNELS) begin
            n1_st = ST_YUV_CHAN;
        end else begin
            n1_st = ST_OK;
        end
        n1_wc  = {3'd0, s_in.width} * {14'd0, s_in.channel_count};
        n1_yw  = round_to_align(STRIDE_W'(s_in.width), i_cfg.luma_row);
        n1_cwh = round_to_align(STRIDE_W'(s_in.width[DIM_W-1:1]), i_cfg.row);
        n1_cwf = round_to_align(STRIDE_W'(s_in.width), i_cfg.row);
        n1_row = round_to_align(STRIDE_W'(n1_wc), i_cfg.row);
    end

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r1_fmt <= s_in.format_class;
            r1_n   <= s_in.batch_count;
            r1_c   <= s_in.channel_count;
            r1_h   <= s_in.height;
            r1_hh  <= s_in.height[DIM_W-1:1];
            r1_yw  <= n1_yw[15:0];
            r1_cwh <= n1_cwh[15:0];
            r1_cwf <= n1_cwf[15:0];
            r1_row <= n1_row[17:0];
            r1_st  <= n1_st;
        end
    end

    always_comb begin
        case (r1_fmt)
            FMT_RGB_PLANAR: n2_sel1 = {2'd0, r1_cwf};
            FMT_PACKED:     n2_sel1 = r1_row;
            default:        n2_sel1 = {2'd0, r1_yw};
        endcase
        n2_sel2 = (r1_fmt == FMT_YUV420) ? r1_cwh : r1_cwf;
    end

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r2_fmt <= r1_fmt;
            r2_n   <= r1_n;
            r2_c   <= r1_c;
            r2_st  <= r1_st;
            r2_m1  <= {18'd0, r1_h} * {14'd0, n2_sel1};
            r2_m2  <= {16'd0, r1_hh} * {13'd0, n2_sel2};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r3_fmt <= r2_fmt;
            r3_n   <= r2_n;
            r3_c   <= r2_c;
            r3_st  <= r2_st;
            r3_m1  <= r2_m1;
            r3_m2  <= r2_m2;
            r3_u   <= round_to_align(STRIDE_W'(r2_m1), i_cfg.plane);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            r4_fmt <= r3_fmt;
            r4_n   <= r3_n;
            r4_c   <= r3_c;
            r4_st  <= r3_st;
            r4_m1  <= r3_m1;
            r4_m2  <= r3_m2;
            r4_u   <= r3_u;
            r4_v   <= round_to_align(r3_u + STRIDE_W'(r3_m2), i_cfg.plane);
        end
    end

    always_comb begin
        case (r4_fmt)
            FMT_YUV420:     n5_stride = round_to_align(r4_v + STRIDE_W'(r4_m2), i_cfg.plane);
            FMT_NV12:       n5_stride = r4_v;
            FMT_RGB_PLANAR: n5_stride = r4_u * STRIDE_W'(r4_c);
            default:        n5_stride = STRIDE_W'(r4_m1);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en[5]) begin
            r5_n      <= r4_n;
            r5_st     <= r4_st;
            r5_stride <= n5_stride;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[6]) begin
            r6_st   <= r5_st;
            r6_prod <= {{STRIDE_W{1'b0}}, r5_n} * {{BATCH_W{1'b0}}, r5_stride};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[7]) begin
            r7_st <= r6_st;
            if (r6_st != ST_OK) begin
                r7_total <= '0;
            end else if (r6_prod > {{(BATCH_W+STRIDE_W-TOTAL_W){1'b0}}, TOTAL_MAX}) begin
                r7_total <= TOTAL_MAX;
            end else begin
                r7_total <= r6_prod[TOTAL_W-1:0];
            end
        end
    end

    assign s_in.ready        = w_en[1];
    assign m_out.valid       = r_v[NSTG];
    assign m_out.total_bytes = r7_total;
    assign m_out.status      = r7_st;

    a_err_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_out.valid && m_out.status != ST_OK |-> m_out.total_bytes == '0)
        else $error("error result with nonzero size");

    a_full_stall : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_in.ready |-> m_out.valid && !m_out.ready && (&r_v))
        else $error("input stalled while pipeline has room");

    a_status_code : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_out.valid |-> m_out.status == ST_OK || m_out.status == ST_UNSUPPORTED
                        || m_out.status == ST_YUV_CHAN)
        else $error("illegal status code");

    a_reset_empty : assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !m_out.valid)
        else $error("result valid right after reset");

endmodule
